FILE: rtl/isba_pkg.sv
// isba_pkg: shared constants, status and op codes, helpers
// for the inode and sector bitmap allocator; no dependencies
`default_nettype none
package isba_pkg;
	localparam int INODE_BITS_DEF  = 4096;
	localparam int SECTOR_BITS_DEF = 65536;
	localparam int ROOT_RUN_DEF    = 3;

	localparam logic [1:0] OP_ALLOC_INODE = 2'd0;
	localparam logic [1:0] OP_ALLOC_SECT  = 2'd1;
	localparam logic [1:0] OP_FREE_INODE  = 2'd2;
	localparam logic [1:0] OP_FREE_SECT   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADBIT = 2'd2;

	localparam logic [1:0] REG_FIRST_DATA = 2'd0;
	localparam logic [1:0] REG_BITS_USED  = 2'd1;

	localparam logic [7:0] FULL_BYTE = 8'hFF;

	typedef logic [7:0] byte_t;

	function automatic logic [2:0] first_one(input byte_t v);
		logic [2:0] r;
		r = 3'd0;
		for (int j = 7; j >= 0; j--) begin
			if (v[j]) r = 3'(j);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/isba_ram.sv
// isba_ram: generic single port ram with registered read
// no dependencies
`default_nettype none
module isba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

FILE: rtl/inode_sector_bitmap_allocator.sv
// inode_sector_bitmap_allocator: first fit inode and sector bitmap allocator
// uses isba_pkg and two isba_ram instances
//
// in channel: op, count, start_req with in_valid / in_stall; out channel:
// number, status with out_valid / out_stall; one result beat per request.
// config: cfg_we, cfg_index, cfg_data; user writes only while the block is idle (unchecked).
// each map byte visited takes a ram read state (S_RD), then an evaluate state
// (S_EV) that writes back through the same port. alloc inode: scan bytes to
// the first clear bit. alloc sectors: scan to first clear bit, then the run's
// bytes twice (check, then write). free inode: one byte read, its bit cleared
// if set; free sectors: the run's bytes twice (check, then write).
// each map has a single memory port, shared by reads and writes.
// after reset a clearing pass writes every sector map byte (inode map written
// in parallel; the first ROOT_RUN_BITS sector bits and inode bits 0 and 1 are set) while in_stall stays high.
// a finished result waits in the output register while out_stall is high;
// the block stays busy until that register can take the next result.
`default_nettype none
module inode_sector_bitmap_allocator
	import isba_pkg::*;
#(
	parameter int INODE_MAP_BITS  = INODE_BITS_DEF,
	parameter int SECTOR_MAP_BITS = SECTOR_BITS_DEF,
	parameter int ROOT_RUN_BITS   = ROOT_RUN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [16:0] count,
	input  wire logic [24:0] start_req,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [24:0]      number,
	output logic [1:0]       status
);
	localparam int IDEPTH = INODE_MAP_BITS / 8;
	localparam int SDEPTH = SECTOR_MAP_BITS / 8;
	localparam int IA = $clog2(IDEPTH);
	localparam int SA = $clog2(SDEPTH);
	localparam int SW = $clog2(SECTOR_MAP_BITS);
	localparam int PW = ((SW > 17) ? SW : 17) + 2;
	localparam int CW = ((SA > IA) ? SA : IA) + 1;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DISP = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_EV   = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	localparam logic [1:0] P_SCAN  = 2'd0;
	localparam logic [1:0] P_CHECK = 2'd1;
	localparam logic [1:0] P_WRITE = 2'd2;

	logic [2:0]    state_q;
	logic [1:0]    ph_q;
	logic [CW-1:0] clr_q;
	logic [23:0]   fds_q;
	logic [16:0]   sbiu_q;
	logic [1:0]    op_q;
	logic [16:0]   cnt_q;
	logic [24:0]   start_q;
	logic [PW-1:0] cur_q, b_q, end_q;
	logic [24:0]   res_num_q;
	logic [1:0]    res_st_q;
	logic          ov_q;
	logic [24:0]   num_q;
	logic [1:0]    st_q;

	logic [PW-1:0] used;
	logic [PW-1:0] pos [8];
	byte_t         ird, srd, rd, cand, bad, runm, wbyte;
	logic          i_we, s_we;
	logic [IA-1:0] i_addr;
	logic [SA-1:0] s_addr;
	byte_t         i_wd, s_wd, s_init;
	logic [26:0]   sbx, endx;
	logic [2:0]    fj;
	logic          last;

	assign used = (sbiu_q > 17'(SECTOR_MAP_BITS) && SW <= 17) ? PW'(SECTOR_MAP_BITS)
		: PW'(sbiu_q);
	assign rd = op_q[0] ? srd : ird;
	assign sbx = 27'(start_q) - 27'(fds_q) + 27'd1;
	assign endx = sbx + 27'(cnt_q);
	assign last = (cur_q + PW'(8)) >= (op_q == OP_ALLOC_INODE ? PW'(INODE_MAP_BITS)
		: (ph_q == P_SCAN ? used : end_q));

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			pos[j] = cur_q + PW'(j);
			runm[j] = (pos[j] >= b_q) && (pos[j] < end_q);
			cand[j] = (pos[j] < used) && !rd[j];
			if (op_q == OP_ALLOC_SECT) bad[j] = runm[j] && ((pos[j] >= used) || rd[j]);
			else bad[j] = runm[j] && !rd[j];
			s_init[j] = ((CW + 3)'(clr_q) * (CW + 3)'(8) + (CW + 3)'(j))
				< (CW + 3)'(ROOT_RUN_BITS);
		end
		if (op_q == OP_ALLOC_INODE) fj = first_one(~rd);
		else if (ph_q == P_SCAN) fj = first_one(cand);
		else fj = first_one(bad);
	end

	always_comb begin
		wbyte = rd;
		case (op_q)
			OP_ALLOC_INODE: wbyte = rd | byte_t'(8'd1 << fj);
			OP_FREE_INODE:  wbyte = rd & ~byte_t'(8'd1 << start_q[2:0]);
			OP_ALLOC_SECT:  wbyte = rd | runm;
			default:        wbyte = rd & ~runm;
		endcase
		i_we = 1'b0;
		s_we = 1'b0;
		i_addr = cur_q[IA+2:3];
		s_addr = cur_q[SA+2:3];
		i_wd = wbyte;
		s_wd = wbyte;
		if (state_q == S_CLR) begin
			i_we = clr_q < CW'(IDEPTH);
			s_we = 1'b1;
			i_addr = clr_q[IA-1:0];
			s_addr = clr_q[SA-1:0];
			i_wd = (clr_q == '0) ? 8'h03 : 8'h00;
			s_wd = s_init;
		end else if (state_q == S_EV) begin
			if (op_q == OP_ALLOC_INODE) i_we = rd != FULL_BYTE;
			else if (op_q == OP_FREE_INODE) i_we = rd[start_q[2:0]];
			else s_we = ph_q == P_WRITE;
		end
	end

	isba_ram #(.WIDTH(8), .DEPTH(IDEPTH)) u_iram (
		.clk(clk), .we(i_we), .addr(i_addr), .wdata(i_wd), .rdata(ird)
	);
	isba_ram #(.WIDTH(8), .DEPTH(SDEPTH)) u_sram (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(srd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ph_q <= P_SCAN;
			clr_q <= '0;
			fds_q <= '0;
			sbiu_q <= 17'd65536;
			ov_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_DATA: fds_q <= cfg_data;
					REG_BITS_USED:  sbiu_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(SDEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q <= op;
						cnt_q <= count;
						start_q <= start_req;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					res_num_q <= '0;
					res_st_q <= ST_OK;
					ph_q <= P_SCAN;
					cur_q <= '0;
					b_q <= '0;
					end_q <= '0;
					state_q <= S_RD;
					case (op_q)
						OP_FREE_INODE: begin
							if (start_q >= 25'(INODE_MAP_BITS)) begin
								res_st_q <= ST_BADBIT;
								state_q <= S_DONE;
							end else begin
								cur_q <= PW'({start_q[24:3], 3'b000});
							end
						end
						OP_ALLOC_SECT: begin
							if (cnt_q == '0) state_q <= S_DONE;
						end
						OP_FREE_SECT: begin
							if (cnt_q == '0) begin
								state_q <= S_DONE;
							end else if (sbx[26] || endx > 27'(used)) begin
								res_st_q <= ST_BADBIT;
								state_q <= S_DONE;
							end else begin
								ph_q <= P_CHECK;
								b_q <= PW'(sbx);
								end_q <= PW'(endx);
								cur_q <= PW'({sbx[26:3], 3'b000});
							end
						end
						default: ;
					endcase
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					state_q <= S_RD;
					case (op_q)
						OP_ALLOC_INODE: begin
							if (rd != FULL_BYTE) begin
								res_num_q <= 25'(pos[fj]);
								state_q <= S_DONE;
							end else if (last) begin
								res_st_q <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								cur_q <= cur_q + PW'(8);
							end
						end
						OP_FREE_INODE: begin
							if (!rd[start_q[2:0]]) res_st_q <= ST_BADBIT;
							state_q <= S_DONE;
						end
						default: begin
							if (ph_q == P_SCAN) begin
								if (cand != '0) begin
									b_q <= pos[fj];
									end_q <= pos[fj] + PW'(cnt_q);
									ph_q <= P_CHECK;
								end else if (last) begin
									res_st_q <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									cur_q <= cur_q + PW'(8);
								end
							end else if (ph_q == P_CHECK) begin
								if (bad != '0) begin
									res_st_q <= (op_q == OP_ALLOC_SECT && pos[fj] >= used)
										? ST_FULL : ST_BADBIT;
									state_q <= S_DONE;
								end else if (last) begin
									ph_q <= P_WRITE;
									cur_q <= {b_q[PW-1:3], 3'b000};
								end else begin
									cur_q <= cur_q + PW'(8);
								end
							end else begin
								if (last) begin
									if (op_q == OP_ALLOC_SECT)
										res_num_q <= 25'(b_q) - 25'd1 + 25'(fds_q);
									state_q <= S_DONE;
								end else begin
									cur_q <= cur_q + PW'(8);
								end
							end
						end
					endcase
				end
				S_DONE: begin
					if (!ov_q || !out_stall) begin
						ov_q <= 1'b1;
						num_q <= res_num_q;
						st_q <= res_st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = state_q != S_IDLE;
	assign out_valid = ov_q;
	assign number = num_q;
	assign status = st_q;

	a_no_ram_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(i_we || s_we))
		else $error("map written while idle");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_BADBIT))
		else $error("bad status code");
	a_err_number_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (number == '0))
		else $error("number nonzero on error");
	a_one_map_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV) |-> !(i_we && s_we))
		else $error("both maps written by one beat");
endmodule
`default_nettype wire
